[src/text_mode_console_writer_macros.svh]
// assertion macros shared by the console writer modules
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on the rising clock edge
`define TMCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcw: %m check failed");
// next-cycle implication
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcw: %m check failed");
`else
`define TMCW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/tmcw_pkg.sv]
`default_nettype none

package tmcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int MODE_W = 2;
    localparam int CH_W   = 8;
    localparam int ATTR_W = 8;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_LF    = 8'd10;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

    localparam logic [CH_W-1:0] COLOR_RESET = 8'd0;
    localparam logic [CH_W-1:0] COLOR_FG_LO = 8'd30;
    localparam logic [CH_W-1:0] COLOR_FG_HI = 8'd37;
    localparam logic [CH_W-1:0] COLOR_BG_LO = 8'd40;
    localparam logic [CH_W-1:0] COLOR_BG_HI = 8'd47;

    localparam int TAB_SPACES = 4;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   color_sel;
        logic [LOC_W-1:0]  read_address;
    } in_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_loc;
        logic [CELL_W-1:0] read_data;
        logic              scrolled;
        logic [ATTR_W-1:0] attribute;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic put;
        logic tab_dec;
        logic color;
        logic scroll_init;
        logic copy;
        logic drain;
        logic fill;
        logic clear_init;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              row_over;
        logic              tab_more;
        logic              copy_last;
        logic              ptr_last;
        logic              out_free;
    } status_t;

endpackage

`default_nettype wire

[src/text_mode_console_writer.sv]
// put character: accept, dispatch, put, put check, done; a tab repeats put for four spaces
// a scroll shifts one cell per cycle through the cell ram port pair, then blanks the last row
// color and read go from dispatch straight to done; clear writes one blank cell per cycle
// one transaction in flight; a new one is taken while the last result waits in the output register
// reset (async, active low): cursor to 0, attribute 0x07, no result pending; cells hold no reset
`default_nettype none

module text_mode_console_writer #(
    parameter int ROWS = tmcw_pkg::ROWS_DEF,
    parameter int COLS = tmcw_pkg::COLS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire tmcw_pkg::in_t  item,
    output logic                result_valid,
    input  wire logic           result_ready,
    output tmcw_pkg::out_t      result
);

    tmcw_pkg::cmd_t    cmd;
    tmcw_pkg::status_t status;

    tmcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    tmcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

`default_nettype wire

[src/tmcw_ram.sv]
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/tmcw_ctrl.sv]
`default_nettype none
`include "text_mode_console_writer_macros.svh"

module tmcw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    output tmcw_pkg::cmd_t         cmd,
    input  wire tmcw_pkg::status_t status
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_PUT       = 9'b000000100,
        S_PUT_CHECK = 9'b000001000,
        S_COPY      = 9'b000010000,
        S_DRAIN     = 9'b000100000,
        S_FILL      = 9'b001000000,
        S_CLEAR     = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.mode)
                    tmcw_pkg::MODE_PUT:
                    begin
                        state_next = S_PUT;
                    end
                    tmcw_pkg::MODE_COLOR:
                    begin
                        cmd.color  = 1'b1;
                        state_next = S_DONE;
                    end
                    tmcw_pkg::MODE_CLEAR:
                    begin
                        cmd.clear_init = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    default:
                    begin
                        // read: ram address already points at the cell
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_PUT_CHECK;
            end
            S_PUT_CHECK:
            begin
                if (status.row_over)
                begin
                    cmd.scroll_init = 1'b1;
                    state_next      = S_COPY;
                end
                else if (status.tab_more)
                begin
                    cmd.tab_dec = 1'b1;
                    state_next  = S_PUT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_COPY:
            begin
                cmd.copy = 1'b1;
                if (status.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = S_PUT_CHECK;
                end
            end
            S_CLEAR:
            begin
                cmd.fill = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TMCW_ASSERT_NEXT(a_done_to_idle, clk, rst_n, (state_reg == S_DONE) && status.out_free, state_reg == S_IDLE)
    `TMCW_ASSERT_NEXT(a_copy_to_drain, clk, rst_n, (state_reg == S_COPY) && status.copy_last, state_reg == S_DRAIN)
    `TMCW_ASSERT_IMPL(a_ready_in_idle, clk, rst_n, item_ready, state_reg == S_IDLE)

endmodule

`default_nettype wire

[src/tmcw_datapath.sv]
`default_nettype none
`include "text_mode_console_writer_macros.svh"

module tmcw_datapath #(
    parameter int ROWS = tmcw_pkg::ROWS_DEF,
    parameter int COLS = tmcw_pkg::COLS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tmcw_pkg::cmd_t    cmd,
    output tmcw_pkg::status_t      status,
    input  wire tmcw_pkg::in_t     item,
    output tmcw_pkg::out_t         result,
    output logic                   result_valid,
    input  wire logic              result_ready
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CLW   = $clog2(COLS);
    localparam int CXW   = CLW + 1;
    localparam int XW    = (AW > tmcw_pkg::LOC_W) ? AW : tmcw_pkg::LOC_W;

    tmcw_pkg::in_t                 item_reg, item_next;
    logic [tmcw_pkg::TAB_W-1:0]    tab_left_reg, tab_left_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [CLW-1:0]                col_reg, col_next;
    logic [CW-1:0]                 lin_reg, lin_next;
    logic [tmcw_pkg::ATTR_W-1:0]   attr_reg, attr_next;
    logic                          scrolled_reg, scrolled_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 wa_reg, wa_next;
    logic                          pend_reg, pend_next;
    tmcw_pkg::out_t                out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tmcw_pkg::CELL_W-1:0]   ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [tmcw_pkg::CELL_W-1:0]   ram_rdata;

    logic [XW-1:0]                 addr_ext;
    logic                          addr_ok;
    logic [tmcw_pkg::CH_W-1:0]     put_ch;
    logic [tmcw_pkg::CELL_W-1:0]   blank;

    tmcw_ram #(
        .WIDTH (tmcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign addr_ext = XW'(item_reg.read_address);
    assign addr_ok  = addr_ext < XW'(CELLS);
    assign put_ch   = (item_reg.ch == tmcw_pkg::CH_TAB) ? tmcw_pkg::CH_SPACE : item_reg.ch;
    assign blank    = {attr_reg, tmcw_pkg::CH_SPACE};

    always_comb
    begin
        item_next      = item_reg;
        tab_left_next  = tab_left_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        lin_next       = lin_reg;
        attr_next      = attr_reg;
        scrolled_next  = scrolled_reg;
        ptr_next       = ptr_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = blank;
        ram_raddr = addr_ext[AW-1:0];

        if (cmd.load)
        begin
            item_next     = item;
            scrolled_next = 1'b0;
            if ((item.mode == tmcw_pkg::MODE_PUT) && (item.ch == tmcw_pkg::CH_TAB))
            begin
                tab_left_next = tmcw_pkg::TAB_W'(tmcw_pkg::TAB_SPACES - 1);
            end
            else
            begin
                tab_left_next = '0;
            end
        end

        if (cmd.tab_dec)
        begin
            tab_left_next = tab_left_reg - 1'b1;
        end

        if (cmd.put)
        begin
            if (put_ch == tmcw_pkg::CH_CR)
            begin
                lin_next = lin_reg - CW'(col_reg);
                col_next = '0;
            end
            else if (put_ch == tmcw_pkg::CH_LF)
            begin
                lin_next = lin_reg - CW'(col_reg) + CW'(COLS);
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = lin_reg[AW-1:0];
                ram_wdata = {attr_reg, put_ch};
                lin_next  = lin_reg + 1'b1;
                if (col_reg == CLW'(COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end

        if (cmd.color)
        begin
            if (item_reg.color_sel == tmcw_pkg::COLOR_RESET)
            begin
                attr_next = tmcw_pkg::DEFAULT_ATTR;
            end
            else if (item_reg.color_sel inside
                     {[tmcw_pkg::COLOR_FG_LO:tmcw_pkg::COLOR_FG_HI]})
            begin
                attr_next = {attr_reg[7:4], 4'(item_reg.color_sel - tmcw_pkg::COLOR_FG_LO)};
            end
            else if (item_reg.color_sel inside
                     {[tmcw_pkg::COLOR_BG_LO:tmcw_pkg::COLOR_BG_HI]})
            begin
                attr_next = {4'(item_reg.color_sel - tmcw_pkg::COLOR_BG_LO), attr_reg[3:0]};
            end
        end

        if (cmd.scroll_init)
        begin
            ptr_next  = AW'(COLS);
            pend_next = 1'b0;
        end

        // row shift: read one cell per cycle, write it a row higher in the next cycle
        if (cmd.copy)
        begin
            ram_raddr = ptr_reg;
            wa_next   = ptr_reg - AW'(COLS);
            pend_next = 1'b1;
            ptr_next  = ptr_reg + 1'b1;
            if (pend_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata;
            end
        end

        if (cmd.drain)
        begin
            ram_we        = 1'b1;
            ram_waddr     = wa_reg;
            ram_wdata     = ram_rdata;
            ptr_next      = AW'(CELLS - COLS);
            row_next      = RW'(ROWS - 1);
            lin_next      = lin_reg - CW'(COLS);
            scrolled_next = 1'b1;
        end

        if (cmd.clear_init)
        begin
            ptr_next = '0;
        end

        if (cmd.fill)
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg;
            ram_wdata = blank;
            ptr_next  = ptr_reg + 1'b1;
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            out_next.cursor_loc = tmcw_pkg::LOC_W'(lin_reg);
            out_next.scrolled   = scrolled_reg && (item_reg.mode == tmcw_pkg::MODE_PUT);
            out_next.attribute  = attr_reg;
            if ((item_reg.mode == tmcw_pkg::MODE_READ) && addr_ok)
            begin
                out_next.read_data = ram_rdata;
            end
            else
            begin
                out_next.read_data = '0;
            end
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_left_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            lin_reg       <= '0;
            attr_reg      <= tmcw_pkg::DEFAULT_ATTR;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tab_left_reg  <= tab_left_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            lin_reg       <= lin_next;
            attr_reg      <= attr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scrolled_reg <= scrolled_next;
        ptr_reg      <= ptr_next;
        wa_reg       <= wa_next;
        out_reg      <= out_next;
    end

    assign status.mode      = item_reg.mode;
    assign status.row_over  = row_reg == RW'(ROWS);
    assign status.tab_more  = tab_left_reg != '0;
    assign status.copy_last = ptr_reg == AW'(CELLS - 1);
    assign status.ptr_last  = ptr_reg == AW'(CELLS - 1);
    assign status.out_free  = !out_valid_reg || result_ready;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    `TMCW_ASSERT_IMPL(a_col_range, clk, rst_n, 1'b1, CXW'(col_reg) < CXW'(COLS))
    `TMCW_ASSERT_IMPL(a_row_at_finish, clk, rst_n, cmd.finish, row_reg < RW'(ROWS))
    `TMCW_ASSERT_NEXT(a_drain_moves_up, clk, rst_n, cmd.drain, (row_reg == RW'(ROWS - 1)) && scrolled_reg)

endmodule

`default_nettype wire
